// ===== rtl/big_endian_load_store_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Big-endian load/store unit assertion macros
// Shared property wrappers; they expect clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef BIG_ENDIAN_LOAD_STORE_UNIT_DEFINES_SVH
`define BIG_ENDIAN_LOAD_STORE_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BELS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Same-cycle property failed.");

// Antecedent implies consequent in the next cycle.
`define BELS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Next-cycle property failed.");

`endif

// ===== rtl/bels_pkg.sv =====
// ----------------------------------------------------------------------------
// Load/store unit package
// Widths, command codes, register indexes and decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bels_pkg;

	localparam int REG_COUNT     = 32;
	localparam int REG_IDX_W     = $clog2(REG_COUNT);
	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_BYTES     = 1 << MEM_ADDR_BITS;
	localparam int CMD_W         = 4;
	localparam int DISP_W        = 16;
	localparam int WORD_W        = 32;
	localparam int WLEN_W        = 17;
	localparam int WLEN_RESET    = 65536;
	localparam int CFG_IDX_W     = 1;
	localparam int LANES         = 4;
	localparam int LANE_W        = $clog2(LANES);
	localparam int ROW_W         = MEM_ADDR_BITS - LANE_W;
	localparam int ROWS          = 1 << ROW_W;
	localparam int LIM_W         = MEM_ADDR_BITS + 1;
	localparam int LIM_RESET     = (WLEN_RESET > MEM_BYTES) ? MEM_BYTES : WLEN_RESET;
	localparam int SIZE_W        = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_LWZ  = 4'd0,
		CMD_LWZU = 4'd1,
		CMD_LBZ  = 4'd2,
		CMD_LBZU = 4'd3,
		CMD_LHZ  = 4'd4,
		CMD_STW  = 4'd5,
		CMD_STWU = 4'd6,
		CMD_STB  = 4'd7,
		CMD_STBU = 4'd8,
		CMD_STH  = 4'd9
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIN_BASE = 1'b0,
		CFG_WIN_LEN  = 1'b1
	} cfg_idx_t;

	typedef enum logic [SIZE_W-1:0] {
		SZ_NONE = 3'd0,
		SZ_BYTE = 3'd1,
		SZ_HALF = 3'd2,
		SZ_WORD = 3'd4
	} size_t;

	typedef struct packed {
		logic                 ld;
		logic                 st;
		logic                 upd;
		size_t                size;
		logic [REG_IDX_W-1:0] rt;
		logic [REG_IDX_W-1:0] ra;
		logic [DISP_W-1:0]    disp;
	} dec_t;

	function automatic dec_t decode(input logic [CMD_W-1:0] cmd,
			input logic [REG_IDX_W-1:0] rt, input logic [REG_IDX_W-1:0] ra,
			input logic [DISP_W-1:0] disp);
		dec_t d;
		d = '0;
		d.rt = rt;
		d.ra = ra;
		d.disp = disp;
		unique case (cmd_t'(cmd))
			CMD_LWZ: begin
				d.ld = 1'b1; d.size = SZ_WORD;
			end
			CMD_LWZU: begin
				d.ld = 1'b1; d.upd = 1'b1; d.size = SZ_WORD;
			end
			CMD_LBZ: begin
				d.ld = 1'b1; d.size = SZ_BYTE;
			end
			CMD_LBZU: begin
				d.ld = 1'b1; d.upd = 1'b1; d.size = SZ_BYTE;
			end
			CMD_LHZ: begin
				d.ld = 1'b1; d.size = SZ_HALF;
			end
			CMD_STW: begin
				d.st = 1'b1; d.size = SZ_WORD;
			end
			CMD_STWU: begin
				d.st = 1'b1; d.upd = 1'b1; d.size = SZ_WORD;
			end
			CMD_STB: begin
				d.st = 1'b1; d.size = SZ_BYTE;
			end
			CMD_STBU: begin
				d.st = 1'b1; d.upd = 1'b1; d.size = SZ_BYTE;
			end
			CMD_STH: begin
				d.st = 1'b1; d.size = SZ_HALF;
			end
			default: begin
				d.size = SZ_NONE;
			end
		endcase
		return d;
	endfunction

	// True if an instruction in flight will write register r.
	function automatic logic wr_hits(input dec_t d, input logic [REG_IDX_W-1:0] r);
		return (d.ld && (d.rt == r)) || (d.upd && (d.ra == r));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bels_ifs.sv =====
// ----------------------------------------------------------------------------
// Load/store unit channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bels_req_if;
	logic                                valid;
	logic                                ready;
	logic [bels_pkg::CMD_W-1:0]          cmd;
	logic [bels_pkg::REG_IDX_W-1:0]      target_reg;
	logic [bels_pkg::REG_IDX_W-1:0]      base_reg;
	logic signed [bels_pkg::DISP_W-1:0]  displacement;

	modport source (output valid, cmd, target_reg, base_reg, displacement, input ready);
	modport sink (input valid, cmd, target_reg, base_reg, displacement, output ready);
endinterface

interface bels_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bels_pkg::WORD_W-1:0]  effective_address;
	logic                         access_ok;
	logic [bels_pkg::WORD_W-1:0]  load_value;

	modport source (output valid, effective_address, access_ok, load_value, input ready);
	modport sink (input valid, effective_address, access_ok, load_value, output ready);
endinterface

interface bels_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bels_pkg::CFG_IDX_W-1:0]  index;
	logic [bels_pkg::WORD_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/big_endian_load_store_unit.sv =====
// ----------------------------------------------------------------------------
// Big-endian load/store unit
// Executes D-form word, halfword and byte loads and stores, with update forms,
// against a 32-entry register file and a byte-addressed data memory. After
// reset the unit clears all 16384 rows of its data memory, one 32-bit row per
// cycle, and holds req.ready low until done. It then takes one transaction per
// cycle through four stages: register read, address, memory access, and
// register write-back, unless a register hazard, an update load's second write
// or response back-pressure stalls it. A transaction that reads a register
// written by one of the three transactions ahead of it waits until that write
// completes, and longer while the response channel holds back. A performed
// update load whose base and target registers differ writes its target, then
// its base register, since the register file has one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module big_endian_load_store_unit (
	input  logic        clk,
	input  logic        arst_n,
	bels_req_if.sink    req,
	bels_rsp_if.source  rsp,
	bels_cfg_if.sink    cfg
);
	import bels_pkg::*;

	`include "big_endian_load_store_unit_defines.svh"

	logic [WORD_W-1:0]    win_base_q;
	logic [LIM_W-1:0]     lim_q;
	logic [WORD_W:0]      len_ext;

	logic                 clr_busy_q;
	logic [ROW_W-1:0]     clr_cnt_q;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	dec_t                 dec_s1, dec_s2, dec_s3, dec_s4;

	logic [WORD_W-1:0]    rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;
	logic [WORD_W-1:0]    rfa_s2, rft_s2;
	logic                 rfa_ok_s2, rft_ok_s2;
	logic                 rf_we;
	logic [REG_IDX_W-1:0] rf_waddr;
	logic [WORD_W-1:0]    rf_wdata;

	logic [WORD_W-1:0]    base_c, ext_c, ea_c, off_c;
	logic [WORD_W-1:0]    ea_s3, off_s3, rtv_s3;
	logic                 ok_c, st_go, mem_re;

	logic [7:0]           dmem [LANES][ROWS];
	logic [LANE_W-1:0]    lane_idx [LANES];
	logic [LANE_W-1:0]    lane_sh [LANES];
	logic [LANES-1:0]     lane_in;
	logic [LANES-1:0]     lane_we;
	logic [ROW_W-1:0]     lane_addr [LANES];
	logic [7:0]           lane_wd [LANES];

	logic [WORD_W-1:0]    ea_s4;
	logic                 ok_s4;
	logic [LANE_W-1:0]    lo_s4;
	logic [7:0]           rd_s4 [LANES];
	logic [7:0]           byte_c [LANES];
	logic [WORD_W-1:0]    loaded_c;
	logic                 wr_load, wr_upd, first_wr, phase_q;

	logic                 out_vld_q, ok_q;
	logic [WORD_W-1:0]    ea_q, lv_q;

	logic                 acc, hazard, s1_issue, s2_adv, s3_adv, s4_done;
	logic                 s2_free, s3_free, s4_free;
	logic                 need_a, need_t;

	// Configuration.
	assign cfg.ready = 1'b1;
	assign len_ext = (WORD_W+1)'(cfg.data[WLEN_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_base_q <= '0;
			lim_q      <= LIM_W'(LIM_RESET);
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_WIN_BASE: begin
					win_base_q <= cfg.data;
				end
				CFG_WIN_LEN: begin
					lim_q <= (len_ext > (WORD_W+1)'(MEM_BYTES)) ? LIM_W'(MEM_BYTES)
					                                            : LIM_W'(len_ext);
				end
			endcase
		end
	end

	// Clearing pass over the data memory after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + ROW_W'(1);
			if (clr_cnt_q == ROW_W'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Pipeline control.
	assign need_a = (dec_s1.ra != '0);
	assign need_t = dec_s1.st;

	always_comb begin
		hazard = 1'b0;
		if (vld_s2 && ((need_a && wr_hits(dec_s2, dec_s1.ra)) ||
		               (need_t && wr_hits(dec_s2, dec_s1.rt)))) begin
			hazard = 1'b1;
		end
		if (vld_s3 && ((need_a && wr_hits(dec_s3, dec_s1.ra)) ||
		               (need_t && wr_hits(dec_s3, dec_s1.rt)))) begin
			hazard = 1'b1;
		end
		if (vld_s4 && ((need_a && wr_hits(dec_s4, dec_s1.ra)) ||
		               (need_t && wr_hits(dec_s4, dec_s1.rt)))) begin
			hazard = 1'b1;
		end
	end

	assign wr_load  = dec_s4.ld && ok_s4;
	assign wr_upd   = dec_s4.upd;
	assign first_wr = vld_s4 && wr_load && wr_upd && (dec_s4.rt != dec_s4.ra) && !phase_q;

	assign s4_done  = vld_s4 && !first_wr && (!out_vld_q || rsp.ready);
	assign s4_free  = !vld_s4 || s4_done;
	assign s3_adv   = vld_s3 && s4_free;
	assign s3_free  = !vld_s3 || s3_adv;
	assign s2_adv   = vld_s2 && s3_free;
	assign s2_free  = !vld_s2 || s2_adv;
	assign s1_issue = vld_s1 && !hazard && s2_free;
	assign req.ready = !clr_busy_q && (!vld_s1 || s1_issue);
	assign acc      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			phase_q   <= 1'b0;
			out_vld_q <= 1'b0;
			rf_vld_q  <= '0;
		end else begin
			vld_s1 <= acc || (vld_s1 && !s1_issue);
			vld_s2 <= s1_issue || (vld_s2 && !s2_adv);
			vld_s3 <= s2_adv || (vld_s3 && !s3_adv);
			vld_s4 <= s3_adv || (vld_s4 && !s4_done);
			if (s4_done) begin
				phase_q <= 1'b0;
			end else if (first_wr) begin
				phase_q <= 1'b1;
			end
			if (s4_done) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
		end
	end

	// Register file: two synchronous read ports, one write port.
	always_ff @(posedge clk) begin
		if (s1_issue) begin
			rfa_s2    <= rf_mem[dec_s1.ra];
			rft_s2    <= rf_mem[dec_s1.rt];
			rfa_ok_s2 <= rf_vld_q[dec_s1.ra] && need_a;
			rft_ok_s2 <= rf_vld_q[dec_s1.rt];
		end
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
	end

	// Address stage.
	assign base_c = rfa_ok_s2 ? rfa_s2 : '0;
	assign ext_c  = {{(WORD_W-DISP_W){dec_s2.disp[DISP_W-1]}}, dec_s2.disp};
	assign ea_c   = base_c + ext_c;
	assign off_c  = base_c + ext_c - win_base_q;

	// Memory stage.
	assign ok_c   = (dec_s3.size != SZ_NONE) &&
	                (({1'b0, off_s3} + (WORD_W+1)'(dec_s3.size)) <= (WORD_W+1)'(lim_q));
	assign st_go  = s3_adv && dec_s3.st && ok_c;
	assign mem_re = s3_adv && dec_s3.ld;

	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			lane_idx[b] = LANE_W'(b) - off_s3[LANE_W-1:0];
			lane_in[b]  = SIZE_W'(lane_idx[b]) < SIZE_W'(dec_s3.size);
			lane_sh[b]  = LANE_W'(SIZE_W'(dec_s3.size) - SIZE_W'(1) - SIZE_W'(lane_idx[b]));
			if (clr_busy_q) begin
				lane_addr[b] = clr_cnt_q;
				lane_wd[b]   = '0;
				lane_we[b]   = 1'b1;
			end else begin
				lane_addr[b] = off_s3[MEM_ADDR_BITS-1:LANE_W] +
				               ROW_W'(LANE_W'(b) < off_s3[LANE_W-1:0]);
				lane_wd[b]   = rtv_s3[8*lane_sh[b] +: 8];
				lane_we[b]   = st_go && lane_in[b];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < LANES; b++) begin
			if (lane_we[b]) begin
				dmem[b][lane_addr[b]] <= lane_wd[b];
			end
			if (mem_re) begin
				rd_s4[b] <= dmem[b][lane_addr[b]];
			end
		end
	end

	// Write-back stage.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			byte_c[k] = rd_s4[LANE_W'(lo_s4 + LANE_W'(k))];
		end
		unique case (dec_s4.size)
			SZ_WORD: loaded_c = {byte_c[0], byte_c[1], byte_c[2], byte_c[3]};
			SZ_HALF: loaded_c = {16'h0000, byte_c[0], byte_c[1]};
			SZ_BYTE: loaded_c = {24'h000000, byte_c[0]};
			default: loaded_c = '0;
		endcase
	end

	assign rf_we    = vld_s4 && (wr_load || wr_upd);
	assign rf_waddr = (first_wr || !wr_upd) ? dec_s4.rt : dec_s4.ra;
	assign rf_wdata = (first_wr || !wr_upd) ? loaded_c : ea_s4;

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			dec_s1 <= decode(req.cmd, req.target_reg, req.base_reg, req.displacement);
		end
		if (s1_issue) begin
			dec_s2 <= dec_s1;
		end
		if (s2_adv) begin
			dec_s3 <= dec_s2;
			ea_s3  <= ea_c;
			off_s3 <= off_c;
			rtv_s3 <= rft_ok_s2 ? rft_s2 : '0;
		end
		if (s3_adv) begin
			dec_s4 <= dec_s3;
			ea_s4  <= ea_s3;
			ok_s4  <= ok_c;
			lo_s4  <= off_s3[LANE_W-1:0];
		end
		if (s4_done) begin
			ea_q <= ea_s4;
			ok_q <= ok_s4;
			lv_q <= wr_load ? loaded_c : '0;
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.effective_address = ea_q;
	assign rsp.access_ok         = ok_q;
	assign rsp.load_value        = lv_q;

	// A register read never coincides with a write to the same register.
	`BELS_ASSERT_IMP(a_no_rf_race, s1_issue && rf_we,
		(!need_a || rf_waddr != dec_s1.ra) && (!need_t || rf_waddr != dec_s1.rt))
	// Nothing is in flight while the data memory is being cleared.
	`BELS_ASSERT_IMP(a_clear_idle, clr_busy_q, !(vld_s1 || vld_s2 || vld_s3 || vld_s4))
	// A performed store writes exactly as many byte lanes as its size.
	`BELS_ASSERT_IMP(a_store_lanes, st_go, $countones(lane_we) == int'(dec_s3.size))
	// The first write-back phase of an update load is always followed by the second.
	`BELS_ASSERT_NXT(a_two_phase, first_wr, phase_q && vld_s4)

endmodule

`default_nettype wire
